// File: sv/gpa_pkg.sv
// Package for the Gaussian pixel affinity core: widths, register codes, the
// configuration bundle and the sRGB curve and root tables built at elaboration.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gpa_pkg;

    localparam int LIN_W   = 25;
    localparam int LUMA_W  = 16;
    localparam int SIGMA_W = 32;
    localparam int Y_W     = 42;
    localparam int YS_W    = Y_W - 16;
    localparam int FEAT_W  = 18;
    localparam int TERM_W  = 31;
    localparam int P_W     = 31;
    localparam int R_W     = 33;
    localparam int ROOTS   = 24;
    localparam int IP_W    = 7;

    localparam logic [TERM_W-1:0] EXP_LIMIT = 31'h4000_0000;
    localparam logic [32:0]       LOG2E_Q32 = 33'd6196328019;
    localparam logic [R_W-1:0]    ONE_Q32   = 33'h1_0000_0000;
    localparam logic [IP_W-1:0]   IP_ZERO   = 7'd34;

    localparam logic [LUMA_W-1:0] LUMA_RED_RESET   = 16'd13933;
    localparam logic [LUMA_W-1:0] LUMA_GREEN_RESET = 16'd46871;
    localparam logic [LUMA_W-1:0] LUMA_BLUE_RESET  = 16'd4732;

    typedef enum logic [2:0] {
        CFG_GRAY_MODE  = 3'd0,
        CFG_INV_SIG_I  = 3'd1,
        CFG_INV_SIG_X  = 3'd2,
        CFG_LUMA_RED   = 3'd3,
        CFG_LUMA_GREEN = 3'd4,
        CFG_LUMA_BLUE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic              gray_mode;
        logic [SIGMA_W-1:0] inv_sigma_i_sq;
        logic [SIGMA_W-1:0] inv_sigma_x_sq;
        logic [LUMA_W-1:0]  luma_red;
        logic [LUMA_W-1:0]  luma_green;
        logic [LUMA_W-1:0]  luma_blue;
    } cfg_t;

    typedef logic [31:0]      root_tab_t [0:ROOTS];
    typedef logic [LIN_W-1:0] curve_tab_t [0:255];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] s;
        t[0] = 32'h8000_0000;
        for (int i = 1; i <= ROOTS; i++)
        begin
            s    = isqrt64({t[i-1], 32'h0});
            t[i] = s[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

    function automatic logic [63:0] exp2neg_q32(input logic [63:0] p);
        logic [63:0] ip;
        logic [63:0] r;
        ip = p >> 24;
        r  = 64'h1_0000_0000;
        if (ip >= 64'd34)
            return 64'd0;
        for (int i = 1; i <= ROOTS; i++)
        begin
            if (p[24-i])
                r = (r * {32'h0, ROOT_TAB[i]} + 64'h8000_0000) >> 32;
        end
        if (ip == 64'd0)
            return r;
        return (r + (64'd1 << (ip - 64'd1))) >> ip;
    endfunction

    function automatic logic [63:0] nlog2_q24(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] lf;
        x  = xin;
        e  = 64'd0;
        lf = 64'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x < 64'h8000_0000)
            begin
                x = x << 1;
                e = e + 64'd1;
            end
        end
        m = x;
        for (int i = 0; i < 24; i++)
        begin
            m  = (m * m) >> 31;
            lf = lf << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m  = m >> 1;
                lf = lf | 64'd1;
            end
        end
        return ((64'd1 + e) << 24) - lf;
    endfunction

    // The sRGB decode of n/510: linear below 0.04045 (slope 1/12.92), otherwise
    // ((s + 0.055) / 1.055) raised to 2.4.
    function automatic logic [LIN_W-1:0] srgb_decode(input logic [63:0] n);
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] v;
        if (n * 64'd10000 <= 64'd206295)
        begin
            v = (n * 64'd100 * 64'h100_0000 + 64'd329460) / 64'd658920;
            return v[LIN_W-1:0];
        end
        x = ((64'd1000 * n + 64'd28050) << 32) / 64'd538050;
        if (x >= 64'h1_0000_0000)
            return 25'h100_0000;
        p = (nlog2_q24(x) * 64'd12 + 64'd2) / 64'd5;
        v = (exp2neg_q32(p) + 64'd128) >> 8;
        return v[LIN_W-1:0];
    endfunction

    function automatic curve_tab_t build_lin();
        curve_tab_t t;
        for (int c = 0; c < 256; c++)
            t[c] = srgb_decode(64'(2 * c));
        return t;
    endfunction

    function automatic curve_tab_t build_thr();
        curve_tab_t t;
        t[0] = '0;
        for (int k = 1; k < 256; k++)
            t[k] = srgb_decode(64'(2 * k - 1));
        return t;
    endfunction

    localparam curve_tab_t LIN_TAB = build_lin();
    localparam curve_tab_t THR_TAB = build_thr();

endpackage

`default_nettype wire

// File: sv/gpa_front.sv
// Front pipeline of the affinity core: differences, curve lookups, luma, gray
// level search, the two exponent terms and the scaling by log2(e).
// Depends on gpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpa_front #(
    parameter int COORD_BITS = 12
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  gpa_pkg::cfg_t              cfg,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [7:0]                 first_red,
    input  wire  [7:0]                 first_green,
    input  wire  [7:0]                 first_blue,
    input  wire  [7:0]                 second_red,
    input  wire  [7:0]                 second_green,
    input  wire  [7:0]                 second_blue,
    input  wire  [COORD_BITS-1:0]      first_x,
    input  wire  [COORD_BITS-1:0]      first_y,
    input  wire  [COORD_BITS-1:0]      second_x,
    input  wire  [COORD_BITS-1:0]      second_y,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [gpa_pkg::P_W-1:0]    out_p,
    output logic                       out_zero
);

    localparam int STAGES = 8;
    localparam int SP_W   = 2 * COORD_BITS + 1;
    localparam int PI_W   = gpa_pkg::FEAT_W + gpa_pkg::SIGMA_W;
    localparam int PX_W   = SP_W + gpa_pkg::SIGMA_W;

    function automatic logic [7:0] diff8(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [COORD_BITS-1:0] diffc(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Four steps of the binary search for the largest k with ys >= thr[k].
    function automatic logic [7:0] search4(input logic [gpa_pkg::YS_W-1:0] ys,
                                           input logic [7:0] lvl_in,
                                           input logic hi_half);
        logic [7:0] lvl;
        logic [7:0] cand;
        lvl = lvl_in;
        for (int j = 0; j < 4; j++)
        begin
            cand = lvl | (8'd1 << (hi_half ? 7 - j : 3 - j));
            if (ys >= gpa_pkg::YS_W'(gpa_pkg::THR_TAB[cand]))
                lvl = cand;
        end
        return lvl;
    endfunction

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   adv;

    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    assign v_next    = {v_reg[STAGES-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_next[i];
            end
        end
    end

    logic [7:0]                     dr_reg, dg_reg, db_reg;
    logic [COORD_BITS-1:0]          dx_reg, dy_reg;
    logic [gpa_pkg::LIN_W-1:0]      l1r_reg, l1g_reg, l1b_reg;
    logic [gpa_pkg::LIN_W-1:0]      l2r_reg, l2g_reg, l2b_reg;
    logic [gpa_pkg::FEAT_W-1:0]     featc1_reg, featc2_reg, featc3_reg;
    logic [SP_W-1:0]                spat1_reg, spat2_reg, spat3_reg, spat4_reg;
    logic [gpa_pkg::Y_W-1:0]        y1_reg, y2_reg;
    logic [gpa_pkg::YS_W-1:0]       ys1_reg, ys2_reg;
    logic [7:0]                     gh1_reg, gh2_reg;
    logic [7:0]                     g1_reg, g2_reg;
    logic [gpa_pkg::FEAT_W-1:0]     feat_reg;
    logic [gpa_pkg::TERM_W-1:0]     ti_reg, tx_reg;
    logic [29:0]                    t_reg;
    logic                           zero6_reg, zero7_reg;
    logic [gpa_pkg::P_W-1:0]        p_reg;

    logic [gpa_pkg::Y_W-1:0]        y1_next, y2_next;
    logic [7:0]                     dgray;
    logic [PI_W-1:0]                prod_i;
    logic [PX_W-1:0]                prod_x;
    logic [31:0]                    t_sum;
    logic [62:0]                    p_prod;

    always_comb
    begin
        y1_next = gpa_pkg::Y_W'(cfg.luma_red)   * gpa_pkg::Y_W'(l1r_reg)
                + gpa_pkg::Y_W'(cfg.luma_green) * gpa_pkg::Y_W'(l1g_reg)
                + gpa_pkg::Y_W'(cfg.luma_blue)  * gpa_pkg::Y_W'(l1b_reg);
        y2_next = gpa_pkg::Y_W'(cfg.luma_red)   * gpa_pkg::Y_W'(l2r_reg)
                + gpa_pkg::Y_W'(cfg.luma_green) * gpa_pkg::Y_W'(l2g_reg)
                + gpa_pkg::Y_W'(cfg.luma_blue)  * gpa_pkg::Y_W'(l2b_reg);
        dgray   = diff8(g1_reg, g2_reg);
        prod_i  = PI_W'(feat_reg) * PI_W'(cfg.inv_sigma_i_sq);
        prod_x  = PX_W'(spat4_reg) * PX_W'(cfg.inv_sigma_x_sq);
        t_sum   = 32'(ti_reg) + 32'(tx_reg);
        p_prod  = 63'(t_reg) * 63'(gpa_pkg::LOG2E_Q32) + 63'h8000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dr_reg  <= diff8(first_red, second_red);
            dg_reg  <= diff8(first_green, second_green);
            db_reg  <= diff8(first_blue, second_blue);
            dx_reg  <= diffc(first_x, second_x);
            dy_reg  <= diffc(first_y, second_y);
            l1r_reg <= gpa_pkg::LIN_TAB[first_red];
            l1g_reg <= gpa_pkg::LIN_TAB[first_green];
            l1b_reg <= gpa_pkg::LIN_TAB[first_blue];
            l2r_reg <= gpa_pkg::LIN_TAB[second_red];
            l2g_reg <= gpa_pkg::LIN_TAB[second_green];
            l2b_reg <= gpa_pkg::LIN_TAB[second_blue];
        end
        if (adv[1])
        begin
            featc1_reg <= gpa_pkg::FEAT_W'(dr_reg) * gpa_pkg::FEAT_W'(dr_reg)
                        + gpa_pkg::FEAT_W'(dg_reg) * gpa_pkg::FEAT_W'(dg_reg)
                        + gpa_pkg::FEAT_W'(db_reg) * gpa_pkg::FEAT_W'(db_reg);
            spat1_reg  <= SP_W'(dx_reg) * SP_W'(dx_reg) + SP_W'(dy_reg) * SP_W'(dy_reg);
            y1_reg     <= y1_next;
            y2_reg     <= y2_next;
        end
        if (adv[2])
        begin
            featc2_reg <= featc1_reg;
            spat2_reg  <= spat1_reg;
            ys1_reg    <= y1_reg[gpa_pkg::Y_W-1:16];
            ys2_reg    <= y2_reg[gpa_pkg::Y_W-1:16];
            gh1_reg    <= search4(y1_reg[gpa_pkg::Y_W-1:16], 8'd0, 1'b1);
            gh2_reg    <= search4(y2_reg[gpa_pkg::Y_W-1:16], 8'd0, 1'b1);
        end
        if (adv[3])
        begin
            featc3_reg <= featc2_reg;
            spat3_reg  <= spat2_reg;
            g1_reg     <= search4(ys1_reg, gh1_reg, 1'b0);
            g2_reg     <= search4(ys2_reg, gh2_reg, 1'b0);
        end
        if (adv[4])
        begin
            spat4_reg <= spat3_reg;
            feat_reg  <= cfg.gray_mode
                       ? gpa_pkg::FEAT_W'(dgray) * gpa_pkg::FEAT_W'(dgray)
                       : featc3_reg;
        end
        if (adv[5])
        begin
            ti_reg <= (prod_i > PI_W'(gpa_pkg::EXP_LIMIT))
                    ? gpa_pkg::EXP_LIMIT : prod_i[gpa_pkg::TERM_W-1:0];
            tx_reg <= (prod_x > PX_W'(gpa_pkg::EXP_LIMIT))
                    ? gpa_pkg::EXP_LIMIT : prod_x[gpa_pkg::TERM_W-1:0];
        end
        if (adv[6])
        begin
            zero6_reg <= t_sum >= 32'(gpa_pkg::EXP_LIMIT);
            t_reg     <= t_sum[29:0];
        end
        if (adv[7])
        begin
            zero7_reg <= zero6_reg;
            p_reg     <= p_prod[62:32];
        end
    end

    assign out_p    = p_reg;
    assign out_zero = zero7_reg;

endmodule

`default_nettype wire

// File: sv/gpa_exp2.sv
// Power-of-two pipeline of the affinity core: 2^-p as a product of roots, one
// root per stage, then the integer shift and the rounding to the weight format.
// Depends on gpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpa_exp2 #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [gpa_pkg::P_W-1:0]      p,
    input  wire                          zero,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [WEIGHT_FRAC_BITS:0]    weight
);

    localparam int NR     = gpa_pkg::ROOTS;
    localparam int STAGES = NR + 2;
    localparam int W_SH   = 32 - WEIGHT_FRAC_BITS;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   adv;

    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    assign v_next    = {v_reg[STAGES-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (adv[i])
                    v_reg[i] <= v_next[i];
            end
        end
    end

    logic [gpa_pkg::R_W-1:0]  r_reg    [0:NR-1];
    logic [23:0]              frac_reg [0:NR-1];
    logic [gpa_pkg::IP_W-1:0] ip_reg   [0:NR-1];
    logic                     zero_reg [0:NR-1];

    logic [gpa_pkg::R_W-1:0]  r_src    [0:NR-1];
    logic [23:0]              frac_src [0:NR-1];
    logic [gpa_pkg::IP_W-1:0] ip_src   [0:NR-1];
    logic                     zero_src [0:NR-1];
    logic [gpa_pkg::R_W-1:0]  r_next   [0:NR-1];
    logic [64:0]              r_prod   [0:NR-1];

    always_comb
    begin
        r_src[0]    = gpa_pkg::ONE_Q32;
        frac_src[0] = p[23:0];
        ip_src[0]   = p[gpa_pkg::P_W-1:24];
        zero_src[0] = zero || (p[gpa_pkg::P_W-1:24] >= gpa_pkg::IP_ZERO);
        for (int k = 1; k < NR; k++)
        begin
            r_src[k]    = r_reg[k-1];
            frac_src[k] = frac_reg[k-1];
            ip_src[k]   = ip_reg[k-1];
            zero_src[k] = zero_reg[k-1];
        end
        for (int k = 0; k < NR; k++)
        begin
            r_prod[k] = 65'(r_src[k]) * 65'(gpa_pkg::ROOT_TAB[k+1]) + 65'h8000_0000;
            r_next[k] = frac_src[k][23-k] ? r_prod[k][64:32] : r_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NR; k++)
        begin
            if (adv[k])
            begin
                r_reg[k]    <= r_next[k];
                frac_reg[k] <= frac_src[k];
                ip_reg[k]   <= ip_src[k];
                zero_reg[k] <= zero_src[k];
            end
        end
    end

    logic [gpa_pkg::R_W-1:0] q_reg;
    logic                    zq_reg;
    logic [WEIGHT_FRAC_BITS:0] w_reg;
    logic [33:0]             q_rnd;
    logic [33:0]             q_next;
    logic [33:0]             w_sum;

    always_comb
    begin
        q_rnd  = (ip_reg[NR-1] == '0) ? 34'd0
               : 34'd1 << (ip_reg[NR-1] - gpa_pkg::IP_W'(1));
        q_next = (34'(r_reg[NR-1]) + q_rnd) >> ip_reg[NR-1];
        w_sum  = (34'(q_reg) + (34'd1 << (W_SH - 1))) >> W_SH;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NR])
        begin
            q_reg  <= q_next[gpa_pkg::R_W-1:0];
            zq_reg <= zero_reg[NR-1];
        end
        if (adv[NR+1])
            w_reg <= zq_reg ? '0 : w_sum[WEIGHT_FRAC_BITS:0];
    end

    assign weight = w_reg;

endmodule

`default_nettype wire

// File: sv/gaussian_pixel_affinity_core.sv
// Top level of the Gaussian pixel affinity core: configuration registers and
// the two pipeline sections. Depends on gpa_pkg, gpa_front and gpa_exp2.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    first_*/second_* colours and coordinates
//   out       out_valid / out_ready  weight
//   cfg       cfg_write              cfg_index, cfg_data
//
// One pixel pair can enter every cycle while the output is not stalled. Its result passes the
// 8 front stages and the 26 power-of-two stages, 24 of which are the root multiplies, on its
// way to the output register.
// Reset clears the valid bits of every stage and loads the register defaults.
// Each stage holds its transaction while the next is full, so bubbles close up and a
// transaction is still accepted while a result waits at the output as long as some stage
// is empty; with all 34 stages full, in_ready follows out_ready.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_pixel_affinity_core #(
    parameter int COORD_BITS       = 12,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_write,
    input  wire  [2:0]                cfg_index,
    input  wire  [31:0]               cfg_data,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire  [7:0]                first_red,
    input  wire  [7:0]                first_green,
    input  wire  [7:0]                first_blue,
    input  wire  [7:0]                second_red,
    input  wire  [7:0]                second_green,
    input  wire  [7:0]                second_blue,
    input  wire  [COORD_BITS-1:0]     first_x,
    input  wire  [COORD_BITS-1:0]     first_y,
    input  wire  [COORD_BITS-1:0]     second_x,
    input  wire  [COORD_BITS-1:0]     second_y,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [WEIGHT_FRAC_BITS:0] weight
);

    gpa_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gray_mode      <= 1'b0;
            cfg_reg.inv_sigma_i_sq <= '0;
            cfg_reg.inv_sigma_x_sq <= '0;
            cfg_reg.luma_red       <= gpa_pkg::LUMA_RED_RESET;
            cfg_reg.luma_green     <= gpa_pkg::LUMA_GREEN_RESET;
            cfg_reg.luma_blue      <= gpa_pkg::LUMA_BLUE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (gpa_pkg::cfg_index_t'(cfg_index))
                gpa_pkg::CFG_GRAY_MODE:  cfg_reg.gray_mode      <= cfg_data[0];
                gpa_pkg::CFG_INV_SIG_I:  cfg_reg.inv_sigma_i_sq <= cfg_data;
                gpa_pkg::CFG_INV_SIG_X:  cfg_reg.inv_sigma_x_sq <= cfg_data;
                gpa_pkg::CFG_LUMA_RED:   cfg_reg.luma_red       <= cfg_data[15:0];
                gpa_pkg::CFG_LUMA_GREEN: cfg_reg.luma_green     <= cfg_data[15:0];
                gpa_pkg::CFG_LUMA_BLUE:  cfg_reg.luma_blue      <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    logic                    mid_valid;
    logic                    mid_ready;
    logic [gpa_pkg::P_W-1:0] mid_p;
    logic                    mid_zero;

    gpa_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .out_valid    (mid_valid),
        .out_ready    (mid_ready),
        .out_p        (mid_p),
        .out_zero     (mid_zero)
    );

    gpa_exp2 #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .p         (mid_p),
        .zero      (mid_zero),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .weight    (weight)
    );

endmodule

`default_nettype wire

// File: sv/gpa_checker.sv
// Port-level checks for the Gaussian pixel affinity core, with the bind that
// attaches them. Depends on gaussian_pixel_affinity_core.
`timescale 1ns / 1ps
`default_nettype none

module gpa_checker #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      in_ready,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire [WEIGHT_FRAC_BITS:0] weight
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight))
        else $error("stalled result transaction changed");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= (WEIGHT_FRAC_BITS + 1)'(1 << WEIGHT_FRAC_BITS))
        else $error("weight above one");

    a_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input refused while the output stage is empty");

endmodule

bind gaussian_pixel_affinity_core gpa_checker #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_gpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .weight    (weight)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for gaussian_pixel_affinity_core: random and directed pixel
// pairs over several register settings, checked against an in-bench integer predictor.
// Depends on gpa_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

class affinity_board;
    logic [16:0] weights_due[$];
    int          mismatches = 0;

    function void note_pair(logic [16:0] w);
        weights_due.push_back(w);
    endfunction

    function void check_weight(logic [16:0] got);
        logic [16:0] want;
        if (weights_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("weight %0d arrived with nothing outstanding", got);
            return;
        end
        want = weights_due.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("weight mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module testbench;

    localparam logic [2:0]  CFG_UNUSED = 3'd7;
    localparam logic [63:0] SAT_LIMIT  = 64'd64 << 24;
    localparam logic [63:0] LOG2E      = 64'd6196328019;
    localparam int          STALL_MAX  = 3000;

    typedef struct {
        logic [7:0]  r1, g1, b1, r2, g2, b2;
        logic [11:0] x1, y1, x2, y2;
    } pixel_pair_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  first_red, first_green, first_blue;
    logic [7:0]  second_red, second_green, second_blue;
    logic [11:0] first_x, first_y, second_x, second_y;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] weight;

    gpa_pkg::cfg_t model_cfg;
    affinity_board board;
    logic [31:0]   root_q32 [0:24];
    logic [24:0]   lin_q24 [0:255];
    logic [24:0]   thr_q24 [0:255];
    bit            calm;
    int            quiet_cycles;

    gaussian_pixel_affinity_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_red(first_red), .first_green(first_green), .first_blue(first_blue),
        .second_red(second_red), .second_green(second_green), .second_blue(second_blue),
        .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
        .out_valid(out_valid), .out_ready(out_ready), .weight(weight)
    );

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] probe;
        acc   = 0;
        probe = 64'd1 << 62;
        while (probe != 0)
        begin
            if (v >= acc + probe)
            begin
                v   = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
                acc = acc >> 1;
            probe = probe >> 2;
        end
        return acc;
    endfunction

    function automatic logic [63:0] pow2_neg(logic [63:0] p);
        logic [63:0] whole;
        logic [63:0] acc;
        whole = p >> 24;
        acc   = 64'd1 << 32;
        if (whole >= 34)
            return 0;
        for (int i = 1; i <= 24; i++)
            if (p[24-i])
                acc = (acc * root_q32[i] + (64'd1 << 31)) >> 32;
        if (whole == 0)
            return acc;
        return (acc + (64'd1 << (whole - 1))) >> whole;
    endfunction

    function automatic logic [63:0] neg_log2(logic [63:0] x);
        logic [63:0] shifts;
        logic [63:0] frac;
        shifts = 0;
        frac   = 0;
        while (x < (64'd1 << 31))
        begin
            x      = x << 1;
            shifts = shifts + 1;
        end
        for (int i = 0; i < 24; i++)
        begin
            x    = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32))
            begin
                x    = x >> 1;
                frac = frac | 1;
            end
        end
        return ((shifts + 1) << 24) - frac;
    endfunction

    function automatic logic [24:0] to_linear(logic [63:0] n);
        logic [63:0] base;
        logic [63:0] expo;
        if (n * 10000 <= 206295)
            return 25'((n * 100 * (64'd1 << 24) + 329460) / 658920);
        base = ((1000 * n + 28050) << 32) / 538050;
        if (base >= (64'd1 << 32))
            return 25'd1 << 24;
        expo = (neg_log2(base) * 12 + 2) / 5;
        return 25'((pow2_neg(expo) + 128) >> 8);
    endfunction

    function automatic logic [63:0] gray_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [63:0] luma;
        logic [63:0] level;
        luma = model_cfg.luma_red * 64'(lin_q24[r]) + model_cfg.luma_green * 64'(lin_q24[g])
             + model_cfg.luma_blue * 64'(lin_q24[b]);
        level = 0;
        for (int k = 1; k < 256; k++)
            if (luma >= (64'(thr_q24[k]) << 16))
                level++;
        return level;
    endfunction

    function automatic logic [63:0] abs_gap(logic [63:0] a, logic [63:0] b);
        return a >= b ? a - b : b - a;
    endfunction

    function automatic logic [63:0] capped(logic [63:0] a, logic [63:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod >= SAT_LIMIT ? SAT_LIMIT : prod;
    endfunction

    function automatic logic [16:0] affinity_of(pixel_pair_t pp);
        logic [63:0] feature, spatial, d, t, p, q;
        if (model_cfg.gray_mode)
        begin
            d       = abs_gap(gray_of(pp.r1, pp.g1, pp.b1), gray_of(pp.r2, pp.g2, pp.b2));
            feature = d * d;
        end
        else
            feature = abs_gap(pp.r1, pp.r2) ** 2 + abs_gap(pp.g1, pp.g2) ** 2
                    + abs_gap(pp.b1, pp.b2) ** 2;
        spatial = abs_gap(pp.x1, pp.x2) ** 2 + abs_gap(pp.y1, pp.y2) ** 2;
        t = capped(feature, model_cfg.inv_sigma_i_sq) + capped(spatial, model_cfg.inv_sigma_x_sq);
        if (t >= SAT_LIMIT)
            return 0;
        p = (t * LOG2E + (64'd1 << 31)) >> 32;
        q = pow2_neg(p);
        return 17'((q + (64'd1 << 15)) >> 16);
    endfunction

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_pair(affinity_of('{first_red, first_green, first_blue, second_red,
                second_green, second_blue, first_x, first_y, second_x, second_y}));
        if (rst_n && out_valid && out_ready)
            board.check_weight(weight);
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 8);

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 0;
        case (idx)
            gpa_pkg::CFG_GRAY_MODE:  model_cfg.gray_mode      = val[0];
            gpa_pkg::CFG_INV_SIG_I:  model_cfg.inv_sigma_i_sq = val;
            gpa_pkg::CFG_INV_SIG_X:  model_cfg.inv_sigma_x_sq = val;
            gpa_pkg::CFG_LUMA_RED:   model_cfg.luma_red       = val[15:0];
            gpa_pkg::CFG_LUMA_GREEN: model_cfg.luma_green     = val[15:0];
            gpa_pkg::CFG_LUMA_BLUE:  model_cfg.luma_blue      = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] gm, logic [31:0] si, logic [31:0] sx,
                           logic [31:0] lr, logic [31:0] lg, logic [31:0] lb);
        write_reg(gpa_pkg::CFG_GRAY_MODE, gm);
        write_reg(gpa_pkg::CFG_INV_SIG_I, si);
        write_reg(gpa_pkg::CFG_INV_SIG_X, sx);
        write_reg(gpa_pkg::CFG_LUMA_RED, lr);
        write_reg(gpa_pkg::CFG_LUMA_GREEN, lg);
        write_reg(gpa_pkg::CFG_LUMA_BLUE, lb);
    endtask

    task automatic send_pair(pixel_pair_t pp);
        bit took;
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid     <= 1;
        first_red    <= pp.r1;
        first_green  <= pp.g1;
        first_blue   <= pp.b1;
        second_red   <= pp.r2;
        second_green <= pp.g2;
        second_blue  <= pp.b2;
        first_x      <= pp.x1;
        first_y      <= pp.y1;
        second_x     <= pp.x2;
        second_y     <= pp.y2;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.weights_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_pair_t random_pair();
        pixel_pair_t pp;
        pp.r1 = $urandom_range(255);
        pp.g1 = $urandom_range(255);
        pp.b1 = $urandom_range(255);
        pp.x1 = $urandom_range(4095);
        pp.y1 = $urandom_range(4095);
        if ($urandom_range(9) < 7)
        begin
            pp.r2 = pp.r1 + 8'($urandom_range(24)) - 8'd12;
            pp.g2 = pp.g1 + 8'($urandom_range(24)) - 8'd12;
            pp.b2 = pp.b1 + 8'($urandom_range(24)) - 8'd12;
            pp.x2 = pp.x1 + 12'($urandom_range(6)) - 12'd3;
            pp.y2 = pp.y1 + 12'($urandom_range(6)) - 12'd3;
        end
        else
        begin
            pp.r2 = $urandom_range(255);
            pp.g2 = $urandom_range(255);
            pp.b2 = $urandom_range(255);
            pp.x2 = $urandom_range(4095);
            pp.y2 = $urandom_range(4095);
        end
        return pp;
    endfunction

    task automatic directed_set();
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_pair('{255, 255, 255, 255, 255, 255, 4095, 4095, 4095, 4095});
        send_pair('{0, 0, 0, 255, 255, 255, 0, 0, 4095, 4095});
        send_pair('{255, 0, 255, 0, 255, 0, 4095, 0, 0, 4095});
        send_pair('{10, 10, 10, 11, 10, 10, 100, 100, 101, 100});
        send_pair('{77, 140, 33, 77, 140, 33, 2000, 9, 2000, 9});
        send_pair('{128, 64, 32, 130, 60, 40, 5, 5, 7, 3});
    endtask

    initial
    begin
        board     = new();
        rst_n     = 0;
        cfg_write = 0;
        cfg_index = gpa_pkg::CFG_GRAY_MODE;
        cfg_data  = 0;
        in_valid  = 0;
        out_ready = 0;
        calm      = 0;
        quiet_cycles = 0;
        {first_red, first_green, first_blue, second_red, second_green, second_blue} = '0;
        {first_x, first_y, second_x, second_y} = '0;
        model_cfg = '{0, 0, 0, gpa_pkg::LUMA_RED_RESET, gpa_pkg::LUMA_GREEN_RESET,
                      gpa_pkg::LUMA_BLUE_RESET};
        root_q32[0] = 32'h8000_0000;
        for (int i = 1; i <= 24; i++)
            root_q32[i] = 32'(int_sqrt({root_q32[i-1], 32'h0}));
        for (int c = 0; c < 256; c++)
            lin_q24[c] = to_linear(2 * c);
        thr_q24[0] = 0;
        for (int k = 1; k < 256; k++)
            thr_q24[k] = to_linear(2 * k - 1);
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed_set();
        drain();
        set_all(0, 32'd1677, 32'd16777, 13933, 46871, 4732);
        directed_set();
        drain();
        set_all(1, 32'd2000, 32'd30000, 13933, 46871, 4732);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        directed_set();
        drain();
        set_all(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535, 65535, 65535);
        directed_set();
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            calm = (phase == 3);
            set_all(phase % 2, $urandom_range(phase == 5 ? 32'hFFFF : 4000),
                    $urandom_range(phase == 6 ? 32'hFFFF_FFFF : 40000),
                    phase == 7 ? 0 : $urandom_range(65535),
                    phase == 7 ? 0 : $urandom_range(65535),
                    $urandom_range(65535));
            for (int n = 0; n < 50; n++)
                send_pair(random_pair());
            drain();
        end
        calm = 0;
        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.weights_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
sv/gpa_pkg.sv
sv/gpa_front.sv
sv/gpa_exp2.sv
sv/gaussian_pixel_affinity_core.sv
sv/gpa_checker.sv
tb/testbench.sv
